// File: design/smrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smrb_pkg;

  localparam int unsigned SEQ_W            = 8;
  localparam int unsigned SEQ_WINDOW       = 255 / 2;
  localparam int unsigned BUFFER_DEPTH_DEF = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;
  localparam int unsigned RESULT_CAP       = 16;
  localparam int unsigned CAP_W            = $clog2(RESULT_CAP + 1);
  localparam int unsigned STATUS_W         = 3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED  = 3'd0,
    STAT_STALE     = 3'd1,
    STAT_DUPLICATE = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_ZERO      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DUP,
    ST_DRAIN_GO,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic free_found;
  } scan_res_t;

endpackage
`default_nettype wire

// File: design/smrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module smrb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/smrb_scan.sv
`timescale 1ns / 1ps
`default_nettype none
module smrb_scan #(
  parameter int BUFFER_DEPTH = smrb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [smrb_pkg::SEQ_W-1:0]      key,
  input  logic [BUFFER_DEPTH-1:0]         slot_valid,
  output logic [$clog2(BUFFER_DEPTH)-1:0] raddr,
  input  logic [smrb_pkg::SEQ_W-1:0]      rd_seq,
  output smrb_pkg::scan_res_t             res,
  output logic [$clog2(BUFFER_DEPTH)-1:0] hit_idx,
  output logic [$clog2(BUFFER_DEPTH)-1:0] free_idx
);

  import smrb_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);

  logic          issue_act;
  logic [IW-1:0] issue_cnt;
  logic          cmp_act;
  logic [IW-1:0] cmp_idx;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic          match;
  logic          free_here;
  logic          done;

  assign raddr     = issue_cnt;
  assign match     = cmp_act && slot_valid[cmp_idx] && (rd_seq == key);
  assign free_here = cmp_act && !slot_valid[cmp_idx];
  assign done      = cmp_act && (match || (cmp_idx == LAST_IDX));

  assign res.done       = done;
  assign res.hit        = match;
  assign res.free_found = free_found_r || free_here;
  assign hit_idx        = cmp_idx;
  assign free_idx       = free_found_r ? free_idx_r : cmp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_act    <= 1'b0;
      issue_cnt    <= '0;
      cmp_act      <= 1'b0;
      cmp_idx      <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else if (go) begin
      issue_act    <= 1'b1;
      issue_cnt    <= '0;
      cmp_act      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (free_here && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx;
      end
      if (done) begin
        issue_act <= 1'b0;
        cmp_act   <= 1'b0;
      end else if (issue_act) begin
        cmp_act <= 1'b1;
        cmp_idx <= issue_cnt;
        if (issue_cnt == LAST_IDX) begin
          issue_act <= 1'b0;
        end else begin
          issue_cnt <= issue_cnt + 1'b1;
        end
      end else begin
        cmp_act <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/sequenced_message_reorder_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                 Payload
// ------    ------------------------  -------------------------------------------
// input     start, busy (beat when    seq_id, payload_tag
//           start && !busy)
// result    result_strobe (1 cycle)   released, out_seq_id, out_payload_tag,
//                                     arrival_status, last
//
// A zero or stale id is judged in ST_CHECK, which registers its result. Otherwise a slot
// scan checks for duplicates and finds a free slot, then each release and a closing
// scan that finds no match take one slot scan each, one slot compare per cycle; after
// RESULT_CAP releases the ST_FLUSH state replaces the closing scan. Busy drops in the
// cycle the final result is shown.
// Reset clears the valid bits and sets the expected number to 1; the receiver cannot stall.
module sequenced_message_reorder_buffer #(
  parameter int BUFFER_DEPTH = smrb_pkg::BUFFER_DEPTH_DEF,
  parameter int PAYLOAD_BITS = smrb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [smrb_pkg::SEQ_W-1:0]    seq_id,
  input  logic [PAYLOAD_BITS-1:0]       payload_tag,
  output logic                          result_strobe,
  output logic                          released,
  output logic [smrb_pkg::SEQ_W-1:0]    out_seq_id,
  output logic [PAYLOAD_BITS-1:0]       out_payload_tag,
  output logic [smrb_pkg::STATUS_W-1:0] arrival_status,
  output logic                          last
);

  import smrb_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam int RW = SEQ_W + PAYLOAD_BITS;
  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  state_t                  state, state_next;
  logic [SEQ_W-1:0]        seq_r, seq_r_next;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_r_next;
  logic [SEQ_W-1:0]        expected, expected_next;
  logic [BUFFER_DEPTH-1:0] slot_valid, slot_valid_next;
  logic [CAP_W-1:0]        n_rel, n_rel_next;
  logic                    pend_valid, pend_valid_next;
  logic [SEQ_W-1:0]        pend_seq, pend_seq_next;
  logic [PAYLOAD_BITS-1:0] pend_pay, pend_pay_next;

  logic                    strobe_next;
  logic                    released_next;
  logic [SEQ_W-1:0]        out_seq_next;
  logic [PAYLOAD_BITS-1:0] out_pay_next;
  status_t                 status_next;
  logic                    last_next;

  logic                    scan_go;
  logic [SEQ_W-1:0]        scan_key;
  scan_res_t               scan_res;
  logic [IW-1:0]           hit_idx;
  logic [IW-1:0]           free_idx;
  logic [IW-1:0]           raddr;
  logic [RW-1:0]           rdata;
  logic                    ram_we;
  logic [SEQ_W:0]          ahead;

  assign busy     = (state != ST_IDLE);
  assign scan_key = (state == ST_DUP) ? seq_r : expected;
  assign ahead    = (seq_r >= expected) ? ({1'b0, seq_r} - {1'b0, expected})
                  : ({1'b0, seq_r} + {1'b0, SEQ_MAX} - {1'b0, expected});

  smrb_ram #(
    .WIDTH (RW),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata ({seq_r, pay_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  smrb_scan #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .go         (scan_go),
    .key        (scan_key),
    .slot_valid (slot_valid),
    .raddr      (raddr),
    .rd_seq     (rdata[RW-1 -: SEQ_W]),
    .res        (scan_res),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      expected      <= SEQ_W'(1);
      slot_valid    <= '0;
      n_rel         <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      expected      <= expected_next;
      slot_valid    <= slot_valid_next;
      n_rel         <= n_rel_next;
      pend_valid    <= pend_valid_next;
      result_strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    seq_r           <= seq_r_next;
    pay_r           <= pay_r_next;
    pend_seq        <= pend_seq_next;
    pend_pay        <= pend_pay_next;
    released        <= released_next;
    out_seq_id      <= out_seq_next;
    out_payload_tag <= out_pay_next;
    arrival_status  <= status_next;
    last            <= last_next;
  end

  always_comb begin
    state_next      = state;
    seq_r_next      = seq_r;
    pay_r_next      = pay_r;
    expected_next   = expected;
    slot_valid_next = slot_valid;
    n_rel_next      = n_rel;
    pend_valid_next = pend_valid;
    pend_seq_next   = pend_seq;
    pend_pay_next   = pend_pay;
    strobe_next     = 1'b0;
    released_next   = 1'b0;
    out_seq_next    = '0;
    out_pay_next    = '0;
    status_next     = STAT_ACCEPTED;
    last_next       = 1'b1;
    scan_go         = 1'b0;
    ram_we          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          seq_r_next = seq_id;
          pay_r_next = payload_tag;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (seq_r == '0) begin
          strobe_next = 1'b1;
          status_next = STAT_ZERO;
          state_next  = ST_IDLE;
        end else if (ahead > (SEQ_W + 1)'(SEQ_WINDOW)) begin
          strobe_next = 1'b1;
          status_next = STAT_STALE;
          state_next  = ST_IDLE;
        end else begin
          scan_go    = 1'b1;
          state_next = ST_DUP;
        end
      end
      ST_DUP: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            strobe_next = 1'b1;
            status_next = STAT_DUPLICATE;
            state_next  = ST_IDLE;
          end else if (!scan_res.free_found) begin
            strobe_next = 1'b1;
            status_next = STAT_FULL;
            state_next  = ST_IDLE;
          end else begin
            ram_we                    = 1'b1;
            slot_valid_next[free_idx] = 1'b1;
            n_rel_next                = '0;
            pend_valid_next           = 1'b0;
            state_next                = ST_DRAIN_GO;
          end
        end
      end
      ST_DRAIN_GO: begin
        scan_go    = 1'b1;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            // hold the hit until the next scan shows whether it is the final beat
            slot_valid_next[hit_idx] = 1'b0;
            expected_next   = (expected == SEQ_MAX) ? SEQ_W'(1) : expected + 1'b1;
            pend_valid_next = 1'b1;
            pend_seq_next   = expected;
            pend_pay_next   = rdata[PAYLOAD_BITS-1:0];
            n_rel_next      = n_rel + 1'b1;
            if (pend_valid) begin
              strobe_next   = 1'b1;
              released_next = 1'b1;
              out_seq_next  = pend_seq;
              out_pay_next  = pend_pay;
              last_next     = 1'b0;
            end
            if (n_rel == CAP_W'(RESULT_CAP - 1)) begin
              state_next = ST_FLUSH;
            end else begin
              state_next = ST_DRAIN_GO;
            end
          end else begin
            strobe_next = 1'b1;
            if (pend_valid) begin
              released_next = 1'b1;
              out_seq_next  = pend_seq;
              out_pay_next  = pend_pay;
            end
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        strobe_next     = 1'b1;
        released_next   = 1'b1;
        out_seq_next    = pend_seq;
        out_pay_next    = pend_pay;
        pend_valid_next = 1'b0;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
